FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assertion macros used by the checker; sampled on clk, off while rst_n is low.
// Same-cycle implication.
`define PLQ_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plq assertion failed");
// Next-cycle implication.
`define PLQ_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plq assertion failed");
`endif

FILE: hdl/plq_pkg.sv
// Shared types, widths and helpers of the price level order queue.
package plq_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int ID_W      = 32;
  localparam int QTY_W     = 32;
  localparam int HANDLE_W  = 6;
  localparam int SUM_W     = 38;
  localparam int MAP_W     = 64;
  localparam int COL_W     = 6;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_FULL       = 2'd2,
    ST_BAD_HANDLE = 2'd3
  } status_t;

  typedef struct packed {
    logic id;
    logic qty;
    logic nxt;
    logic prv;
  } node_we_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } map_ctl_t;

  // index of the lowest set bit of a map word
  function automatic logic [COL_W-1:0] lowest_set(input logic [MAP_W-1:0] x);
    logic [MAP_W-1:0] iso;
    logic [COL_W-1:0] idx;
    iso = x & (~x + MAP_W'(1));
    idx = '0;
    for (int b = 0; b < MAP_W; b++) begin
      if (iso[b]) idx = idx | COL_W'(b);
    end
    return idx;
  endfunction

endpackage

FILE: hdl/plq_channels.sv
// Valid/ready channel interfaces for operations and results.
interface plq_in_if;
  logic                          valid;
  logic                          ready;
  plq_pkg::op_t                  operation;
  logic [plq_pkg::ID_W-1:0]      order_id;
  logic [plq_pkg::QTY_W-1:0]     order_qty;
  logic [plq_pkg::HANDLE_W-1:0]  slot_handle;

  modport source(output valid, operation, order_id, order_qty, slot_handle, input ready);
  modport sink(input valid, operation, order_id, order_qty, slot_handle, output ready);
endinterface

interface plq_out_if;
  logic                          valid;
  logic                          ready;
  plq_pkg::status_t              status;
  logic [plq_pkg::HANDLE_W-1:0]  new_handle;
  logic [plq_pkg::ID_W-1:0]      popped_id;
  logic [plq_pkg::QTY_W-1:0]     popped_qty;
  logic [plq_pkg::ID_W-1:0]      head_id;
  logic                          is_empty;
  logic [plq_pkg::SUM_W-1:0]     level_total;

  modport source(output valid, status, new_handle, popped_id, popped_qty, head_id, is_empty,
                 level_total, input ready);
  modport sink(input valid, status, new_handle, popped_id, popped_qty, head_id, is_empty,
               level_total, output ready);
endinterface

FILE: hdl/price_level_order_queue.sv
// price_level_order_queue: order FIFO at one price level, a linked list in a node RAM.
// Flow: an operation is taken only in idle. Clear and errors found at transfer (pool full, pop on
// empty, handle out of range, remove on empty) go straight to done; push then link, pop then head,
// remove then unlink or head (an unused handle is flagged in remove); link and unlink are own steps
// as the node RAM has a single write port. Done loads out_ch once it is free, then returns to idle.
// Reset: synchronous rst_n empties the queue and frees every slot at once; no clearing pass.
module price_level_order_queue #(
  parameter int SLOTS = plq_pkg::SLOTS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  plq_in_if.sink    in_ch,
  plq_out_if.source out_ch
);

  localparam int SW    = $clog2(SLOTS);
  localparam int ROWS  = (SLOTS + plq_pkg::MAP_W - 1) / plq_pkg::MAP_W;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = plq_pkg::COL_W;
  localparam int XW    = RW + CW;
  localparam int MW    = plq_pkg::MAP_W;
  localparam int ID_W  = plq_pkg::ID_W;
  localparam int QTY_W = plq_pkg::QTY_W;
  localparam int SUM_W = plq_pkg::SUM_W;
  localparam int HW    = plq_pkg::HANDLE_W;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PUSH   = 8'b0000_0010,
    S_LINK   = 8'b0000_0100,
    S_POP    = 8'b0000_1000,
    S_REM    = 8'b0001_0000,
    S_UNLINK = 8'b0010_0000,
    S_HEAD   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [QTY_W-1:0]    qty_r, qty_nxt;
  logic [SW-1:0]       hs_r, hs_nxt;
  plq_pkg::status_t    status_r, status_nxt;
  logic [ID_W-1:0]     pid_r, pid_nxt;
  logic [QTY_W-1:0]    pqty_r, pqty_nxt;
  logic [SW-1:0]       nh_r, nh_nxt;
  logic [SW-1:0]       head_r, head_nxt;
  logic [SW-1:0]       tail_r, tail_nxt;
  logic                nonempty_r, nonempty_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [ID_W-1:0]     head_id_r, head_id_nxt;
  logic [SW-1:0]       link_n_r, link_n_nxt;
  logic [SW-1:0]       link_p_r, link_p_nxt;
  logic [RW-1:0]       free_row_r, free_row_nxt;

  logic                out_valid_r;
  logic                out_load;
  plq_pkg::status_t    out_status_r;
  logic [HW-1:0]       out_nh_r;
  logic [ID_W-1:0]     out_pid_r;
  logic [QTY_W-1:0]    out_pqty_r;
  logic [ID_W-1:0]     out_head_id_r;
  logic                out_empty_r;
  logic [SUM_W-1:0]    out_sum_r;

  plq_pkg::map_ctl_t   map_ctl;
  logic [RW-1:0]       map_rd_row;
  logic [RW-1:0]       map_wr_row;
  logic [MW-1:0]       map_wr_word;
  logic [MW-1:0]       map_rd_word;
  logic                free_any;
  logic [RW-1:0]       free_row;

  logic                node_rd_en;
  logic [SW-1:0]       node_rd_addr;
  logic [ID_W-1:0]     nd_id;
  logic [QTY_W-1:0]    nd_qty;
  logic [SW-1:0]       nd_nxt;
  logic [SW-1:0]       nd_prv;
  plq_pkg::node_we_t   node_we;
  logic [SW-1:0]       node_wr_addr;
  logic [ID_W-1:0]     node_wr_id;
  logic [QTY_W-1:0]    node_wr_qty;
  logic [SW-1:0]       node_wr_nxt;
  logic [SW-1:0]       node_wr_prv;

  logic [SW-1:0]       hs_in;
  logic                handle_bad;
  logic [XW-1:0]       head_ext;
  logic [XW-1:0]       hs_in_ext;
  logic [XW-1:0]       hs_ext;
  logic [CW-1:0]       push_col;
  logic [SW-1:0]       push_slot;
  logic [MW-1:0]       push_bit;
  logic [MW-1:0]       head_bit;
  logic [MW-1:0]       hs_bit;
  logic                hs_used;

  plq_slot_map #(.SLOTS(SLOTS)) u_slot_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (map_ctl),
    .rd_row   (map_rd_row),
    .wr_row   (map_wr_row),
    .wr_word  (map_wr_word),
    .rd_word  (map_rd_word),
    .free_any (free_any),
    .free_row (free_row)
  );

  plq_node_mem #(.SLOTS(SLOTS)) u_node_mem (
    .clk     (clk),
    .rd_en   (node_rd_en),
    .rd_addr (node_rd_addr),
    .rd_id   (nd_id),
    .rd_qty  (nd_qty),
    .rd_nxt  (nd_nxt),
    .rd_prv  (nd_prv),
    .we      (node_we),
    .wr_addr (node_wr_addr),
    .wr_id   (node_wr_id),
    .wr_qty  (node_wr_qty),
    .wr_nxt  (node_wr_nxt),
    .wr_prv  (node_wr_prv)
  );

  assign hs_in      = SW'(in_ch.slot_handle);
  assign handle_bad = (32'(in_ch.slot_handle) >= 32'(SLOTS));
  assign head_ext   = XW'(head_r);
  assign hs_in_ext  = XW'(hs_in);
  assign hs_ext     = XW'(hs_r);
  assign push_col   = plq_pkg::lowest_set(~map_rd_word);
  assign push_slot  = SW'({free_row_r, push_col});
  assign push_bit   = MW'(1) << push_col;
  assign head_bit   = MW'(1) << head_ext[CW-1:0];
  assign hs_bit     = MW'(1) << hs_ext[CW-1:0];
  assign hs_used    = |(map_rd_word & hs_bit);

  // each item finishes all RAM writes before the next transfer, so no forwarding is needed
  always_comb begin
    state_nxt    = state_r;
    id_nxt       = id_r;
    qty_nxt      = qty_r;
    hs_nxt       = hs_r;
    status_nxt   = status_r;
    pid_nxt      = pid_r;
    pqty_nxt     = pqty_r;
    nh_nxt       = nh_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    nonempty_nxt = nonempty_r;
    sum_nxt      = sum_r;
    head_id_nxt  = head_id_r;
    link_n_nxt   = link_n_r;
    link_p_nxt   = link_p_r;
    free_row_nxt = free_row_r;
    out_load     = 1'b0;

    map_ctl      = '0;
    map_rd_row   = head_ext[XW-1:CW];
    map_wr_row   = free_row_r;
    map_wr_word  = map_rd_word;
    node_rd_en   = 1'b0;
    node_rd_addr = head_r;
    node_we      = '0;
    node_wr_addr = nh_r;
    node_wr_id   = id_r;
    node_wr_qty  = qty_r;
    node_wr_nxt  = nh_r;
    node_wr_prv  = tail_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          id_nxt     = in_ch.order_id;
          qty_nxt    = in_ch.order_qty;
          hs_nxt     = hs_in;
          status_nxt = plq_pkg::ST_OK;
          pid_nxt    = '0;
          pqty_nxt   = '0;
          nh_nxt     = '0;
          case (in_ch.operation)
            plq_pkg::OP_PUSH: begin
              if (!free_any) begin
                status_nxt = plq_pkg::ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                map_ctl.rd   = 1'b1;
                map_rd_row   = free_row;
                free_row_nxt = free_row;
                state_nxt    = S_PUSH;
              end
            end
            plq_pkg::OP_POP: begin
              if (!nonempty_r) begin
                status_nxt = plq_pkg::ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                map_ctl.rd   = 1'b1;
                map_rd_row   = head_ext[XW-1:CW];
                node_rd_en   = 1'b1;
                node_rd_addr = head_r;
                state_nxt    = S_POP;
              end
            end
            plq_pkg::OP_REMOVE: begin
              if (handle_bad || !nonempty_r) begin
                status_nxt = plq_pkg::ST_BAD_HANDLE;
                state_nxt  = S_DONE;
              end else begin
                map_ctl.rd   = 1'b1;
                map_rd_row   = hs_in_ext[XW-1:CW];
                node_rd_en   = 1'b1;
                node_rd_addr = hs_in;
                state_nxt    = S_REM;
              end
            end
            plq_pkg::OP_CLEAR: begin
              map_ctl.clr  = 1'b1;
              nonempty_nxt = 1'b0;
              sum_nxt      = '0;
              state_nxt    = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_PUSH: begin
        map_ctl.wr   = 1'b1;
        map_wr_row   = free_row_r;
        map_wr_word  = map_rd_word | push_bit;
        node_we.id   = 1'b1;
        node_we.qty  = 1'b1;
        node_we.prv  = 1'b1;
        node_wr_addr = push_slot;
        node_wr_prv  = tail_r;
        nh_nxt       = push_slot;
        sum_nxt      = sum_r + SUM_W'(qty_r);
        if (nonempty_r) begin
          state_nxt = S_LINK;
        end else begin
          head_nxt     = push_slot;
          tail_nxt     = push_slot;
          nonempty_nxt = 1'b1;
          head_id_nxt  = id_r;
          state_nxt    = S_DONE;
        end
      end
      S_LINK: begin
        node_we.nxt  = 1'b1;
        node_wr_addr = tail_r;
        node_wr_nxt  = nh_r;
        tail_nxt     = nh_r;
        state_nxt    = S_DONE;
      end
      S_POP: begin
        pid_nxt     = nd_id;
        pqty_nxt    = nd_qty;
        sum_nxt     = sum_r - SUM_W'(nd_qty);
        map_ctl.wr  = 1'b1;
        map_wr_row  = head_ext[XW-1:CW];
        map_wr_word = map_rd_word & ~head_bit;
        if (head_r == tail_r) begin
          nonempty_nxt = 1'b0;
          state_nxt    = S_DONE;
        end else begin
          head_nxt     = nd_nxt;
          node_rd_en   = 1'b1;
          node_rd_addr = nd_nxt;
          state_nxt    = S_HEAD;
        end
      end
      S_REM: begin
        if (!hs_used) begin
          status_nxt = plq_pkg::ST_BAD_HANDLE;
          state_nxt  = S_DONE;
        end else begin
          pid_nxt     = nd_id;
          pqty_nxt    = nd_qty;
          sum_nxt     = sum_r - SUM_W'(nd_qty);
          map_ctl.wr  = 1'b1;
          map_wr_row  = hs_ext[XW-1:CW];
          map_wr_word = map_rd_word & ~hs_bit;
          if (hs_r == head_r && hs_r == tail_r) begin
            nonempty_nxt = 1'b0;
            state_nxt    = S_DONE;
          end else if (hs_r == head_r) begin
            head_nxt     = nd_nxt;
            node_rd_en   = 1'b1;
            node_rd_addr = nd_nxt;
            state_nxt    = S_HEAD;
          end else if (hs_r == tail_r) begin
            tail_nxt  = nd_prv;
            state_nxt = S_DONE;
          end else begin
            node_we.nxt  = 1'b1;
            node_wr_addr = nd_prv;
            node_wr_nxt  = nd_nxt;
            link_n_nxt   = nd_nxt;
            link_p_nxt   = nd_prv;
            state_nxt    = S_UNLINK;
          end
        end
      end
      S_UNLINK: begin
        node_we.prv  = 1'b1;
        node_wr_addr = link_n_r;
        node_wr_prv  = link_p_r;
        state_nxt    = S_DONE;
      end
      S_HEAD: begin
        head_id_nxt = nd_id;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      nonempty_r  <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      nonempty_r <= nonempty_nxt;
      sum_r      <= sum_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    qty_r      <= qty_nxt;
    hs_r       <= hs_nxt;
    status_r   <= status_nxt;
    pid_r      <= pid_nxt;
    pqty_r     <= pqty_nxt;
    nh_r       <= nh_nxt;
    head_id_r  <= head_id_nxt;
    link_n_r   <= link_n_nxt;
    link_p_r   <= link_p_nxt;
    free_row_r <= free_row_nxt;
    if (out_load) begin
      out_status_r  <= status_r;
      out_nh_r      <= HW'(nh_r);
      out_pid_r     <= pid_r;
      out_pqty_r    <= pqty_r;
      out_head_id_r <= nonempty_r ? head_id_r : '0;
      out_empty_r   <= !nonempty_r;
      out_sum_r     <= sum_r;
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.new_handle  = out_nh_r;
  assign out_ch.popped_id   = out_pid_r;
  assign out_ch.popped_qty  = out_pqty_r;
  assign out_ch.head_id     = out_head_id_r;
  assign out_ch.is_empty    = out_empty_r;
  assign out_ch.level_total = out_sum_r;

endmodule

FILE: hdl/plq_slot_map.sv
// Slot occupancy map: row RAM of used bits, per-row valid/full flags, lowest free row.
module plq_slot_map #(
  parameter int SLOTS = plq_pkg::SLOTS_DEF,
  localparam int ROWS = (SLOTS + plq_pkg::MAP_W - 1) / plq_pkg::MAP_W,
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  plq_pkg::map_ctl_t         ctl,
  input  logic [RW-1:0]             rd_row,
  input  logic [RW-1:0]             wr_row,
  input  logic [plq_pkg::MAP_W-1:0] wr_word,
  output logic [plq_pkg::MAP_W-1:0] rd_word,
  output logic                      free_any,
  output logic [RW-1:0]             free_row
);

  localparam int MW        = plq_pkg::MAP_W;
  localparam int LAST_BITS = SLOTS - (ROWS - 1) * MW;
  // slots past the end of the last row read as taken
  localparam logic [MW-1:0] LAST_PAD = ~({MW{1'b1}} >> (MW - LAST_BITS));

  logic [MW-1:0]   map_mem [ROWS];
  logic [MW-1:0]   rd_data_r;
  logic            rd_valid_r;
  logic            rd_last_r;
  logic [ROWS-1:0] row_valid_r, row_valid_nxt;
  logic [ROWS-1:0] row_full_r, row_full_nxt;
  logic [ROWS-1:0] avail;
  logic [ROWS-1:0] avail_low;
  logic [MW-1:0]   wr_pad;

  always_ff @(posedge clk) begin
    if (ctl.wr) map_mem[wr_row] <= wr_word;
    if (ctl.rd) begin
      rd_data_r  <= map_mem[rd_row];
      rd_valid_r <= row_valid_r[rd_row];
      rd_last_r  <= (rd_row == RW'(ROWS - 1));
    end
  end

  assign rd_word = (rd_valid_r ? rd_data_r : '0) | (rd_last_r ? LAST_PAD : '0);
  assign wr_pad  = (wr_row == RW'(ROWS - 1)) ? LAST_PAD : '0;

  always_comb begin
    row_valid_nxt = row_valid_r;
    row_full_nxt  = row_full_r;
    if (ctl.clr) begin
      row_valid_nxt = '0;
      row_full_nxt  = '0;
    end else if (ctl.wr) begin
      row_valid_nxt[wr_row] = 1'b1;
      row_full_nxt[wr_row]  = &(wr_word | wr_pad);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      row_full_r  <= '0;
    end else begin
      row_valid_r <= row_valid_nxt;
      row_full_r  <= row_full_nxt;
    end
  end

  assign avail     = ~(row_valid_r & row_full_r);
  assign avail_low = avail & (~avail + ROWS'(1));
  assign free_any  = |avail;

  always_comb begin
    free_row = '0;
    for (int r = 0; r < ROWS; r++) begin
      if (avail_low[r]) free_row = free_row | RW'(r);
    end
  end

endmodule

FILE: hdl/plq_node_mem.sv
// Node RAM: order id, quantity and both links per slot, with per-field write enables.
module plq_node_mem #(
  parameter int SLOTS = plq_pkg::SLOTS_DEF,
  localparam int SW   = $clog2(SLOTS)
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [SW-1:0]             rd_addr,
  output logic [plq_pkg::ID_W-1:0]  rd_id,
  output logic [plq_pkg::QTY_W-1:0] rd_qty,
  output logic [SW-1:0]             rd_nxt,
  output logic [SW-1:0]             rd_prv,
  input  plq_pkg::node_we_t         we,
  input  logic [SW-1:0]             wr_addr,
  input  logic [plq_pkg::ID_W-1:0]  wr_id,
  input  logic [plq_pkg::QTY_W-1:0] wr_qty,
  input  logic [SW-1:0]             wr_nxt,
  input  logic [SW-1:0]             wr_prv
);

  localparam int PRV_LO = 0;
  localparam int NXT_LO = SW;
  localparam int QTY_LO = 2 * SW;
  localparam int ID_LO  = QTY_LO + plq_pkg::QTY_W;
  localparam int NODE_W = ID_LO + plq_pkg::ID_W;

  logic [NODE_W-1:0] node_mem [SLOTS];
  logic [NODE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we.id)  node_mem[wr_addr][ID_LO +: plq_pkg::ID_W]   <= wr_id;
    if (we.qty) node_mem[wr_addr][QTY_LO +: plq_pkg::QTY_W] <= wr_qty;
    if (we.nxt) node_mem[wr_addr][NXT_LO +: SW]             <= wr_nxt;
    if (we.prv) node_mem[wr_addr][PRV_LO +: SW]             <= wr_prv;
    if (rd_en)  rd_data_r <= node_mem[rd_addr];
  end

  assign rd_id  = rd_data_r[ID_LO +: plq_pkg::ID_W];
  assign rd_qty = rd_data_r[QTY_LO +: plq_pkg::QTY_W];
  assign rd_nxt = rd_data_r[NXT_LO +: SW];
  assign rd_prv = rd_data_r[PRV_LO +: SW];

endmodule

FILE: hdl/plq_checker.sv
// Port-level checker for the price level order queue, with its bind.
`include "assert_macros.svh"

module plq_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input plq_pkg::status_t             status,
  input logic [plq_pkg::HANDLE_W-1:0] new_handle,
  input logic [plq_pkg::ID_W-1:0]     popped_id,
  input logic [plq_pkg::QTY_W-1:0]    popped_qty,
  input logic [plq_pkg::ID_W-1:0]     head_id,
  input logic                         is_empty,
  input logic [plq_pkg::SUM_W-1:0]    level_total
);

  `PLQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(level_total) && $stable(popped_id))
  `PLQ_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `PLQ_ASSERT_IMP(a_empty_clean, out_valid && is_empty, (head_id == '0) && (level_total == '0))
  `PLQ_ASSERT_IMP(a_empty_pop, out_valid && (status == plq_pkg::ST_EMPTY), is_empty)
  `PLQ_ASSERT_IMP(a_err_no_payload, out_valid && (status != plq_pkg::ST_OK), (new_handle == '0) && (popped_id == '0) && (popped_qty == '0))

endmodule

bind price_level_order_queue plq_checker u_plq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .new_handle  (out_ch.new_handle),
  .popped_id   (out_ch.popped_id),
  .popped_qty  (out_ch.popped_qty),
  .head_id     (out_ch.head_id),
  .is_empty    (out_ch.is_empty),
  .level_total (out_ch.level_total)
);

FILE: tb/tb_price_level_order_queue.sv
// Testbench for price_level_order_queue: random and directed push/pop/remove/clear checked against a predictor.
`timescale 1ns / 100ps

module tb_price_level_order_queue;
  import plq_pkg::*;

  localparam int NSLOT      = SLOTS_DEF;
  localparam int STALL_MAX  = 5000;
  localparam int PRINT_MAX  = 40;

  typedef struct packed {
    op_t                 op;
    logic [ID_W-1:0]     order_id;
    logic [QTY_W-1:0]    order_qty;
    logic [HANDLE_W-1:0] slot_handle;
    logic                pick_live;
  } plq_item_t;

  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] new_handle;
    logic [ID_W-1:0]     popped_id;
    logic [QTY_W-1:0]    popped_qty;
    logic [ID_W-1:0]     head_id;
    logic                is_empty;
    logic [SUM_W-1:0]    level_total;
  } plq_result_t;

  logic clk;
  logic rst_n;

  plq_in_if  in_ch();
  plq_out_if out_ch();

  price_level_order_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state
  logic [ID_W-1:0]     ord_id_mem [NSLOT];
  logic [QTY_W-1:0]    ord_qty_mem[NSLOT];
  logic [HANDLE_W-1:0] fwd_link   [NSLOT];
  logic [HANDLE_W-1:0] back_link  [NSLOT];
  logic [NSLOT-1:0]    slot_busy;
  logic [HANDLE_W-1:0] head_slot_q;
  logic [HANDLE_W-1:0] tail_slot_q;
  logic                has_orders;
  logic [SUM_W-1:0]    level_sum;

  plq_item_t   pending_ops[$];
  plq_result_t expected_results[$];
  plq_item_t   cur_op;

  int send_idle_pct;
  int recv_idle_pct;
  int errors;
  int results_seen;
  int stall_cycles;
  int op_count[4];
  int status_count[4];

  initial begin
    clk = 1'b0;
  end

  always #4 clk = ~clk;

  function automatic plq_result_t predict_op(plq_item_t it);
    plq_result_t         r;
    logic [HANDLE_W-1:0] s;
    logic [HANDLE_W-1:0] p;
    logic [HANDLE_W-1:0] n;
    bit                  found;
    r = '0;
    r.status = ST_OK;
    found = 1'b0;
    s = '0;
    case (it.op)
      OP_PUSH: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (!found && !slot_busy[i]) begin
            s = HANDLE_W'(i);
            found = 1'b1;
          end
        end
        if (!found) begin
          r.status = ST_FULL;
        end else begin
          slot_busy[s] = 1'b1;
          ord_id_mem[s] = it.order_id;
          ord_qty_mem[s] = it.order_qty;
          if (has_orders) begin
            fwd_link[tail_slot_q] = s;
            back_link[s] = tail_slot_q;
            tail_slot_q = s;
          end else begin
            head_slot_q = s;
            tail_slot_q = s;
            has_orders = 1'b1;
          end
          level_sum = level_sum + SUM_W'(it.order_qty);
          r.new_handle = s;
        end
      end
      OP_POP: begin
        if (!has_orders) begin
          r.status = ST_EMPTY;
        end else begin
          s = head_slot_q;
          r.popped_id = ord_id_mem[s];
          r.popped_qty = ord_qty_mem[s];
          slot_busy[s] = 1'b0;
          if (s == tail_slot_q) has_orders = 1'b0;
          else head_slot_q = fwd_link[s];
          level_sum = level_sum - SUM_W'(r.popped_qty);
        end
      end
      OP_REMOVE: begin
        s = it.slot_handle;
        if (!slot_busy[s] || !has_orders) begin
          r.status = ST_BAD_HANDLE;
        end else begin
          r.popped_id = ord_id_mem[s];
          r.popped_qty = ord_qty_mem[s];
          if (s == head_slot_q && s == tail_slot_q) begin
            has_orders = 1'b0;
          end else if (s == head_slot_q) begin
            head_slot_q = fwd_link[s];
          end else if (s == tail_slot_q) begin
            tail_slot_q = back_link[s];
          end else begin
            p = back_link[s];
            n = fwd_link[s];
            fwd_link[p] = n;
            back_link[n] = p;
          end
          slot_busy[s] = 1'b0;
          level_sum = level_sum - SUM_W'(r.popped_qty);
        end
      end
      default: begin
        slot_busy = '0;
        has_orders = 1'b0;
        level_sum = '0;
      end
    endcase
    r.head_id = has_orders ? ord_id_mem[head_slot_q] : '0;
    r.is_empty = !has_orders;
    r.level_total = level_sum;
    return r;
  endfunction

  // pick a queued slot at drive time so removes mostly hit live orders
  function automatic logic [HANDLE_W-1:0] live_handle(logic [HANDLE_W-1:0] fallback);
    int busy_list[$];
    for (int i = 0; i < NSLOT; i++) begin
      if (slot_busy[i]) busy_list.push_back(i);
    end
    if (busy_list.size() == 0) return fallback;
    return HANDLE_W'(busy_list[$urandom_range(busy_list.size() - 1)]);
  endfunction

  function automatic logic [31:0] rand_word();
    int pick;
    pick = $urandom_range(7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom;
  endfunction

  task automatic queue_op(op_t op, logic [ID_W-1:0] id, logic [QTY_W-1:0] qty,
                          logic [HANDLE_W-1:0] handle, bit live);
    plq_item_t it;
    it.op = op;
    it.order_id = id;
    it.order_qty = qty;
    it.slot_handle = handle;
    it.pick_live = live;
    pending_ops.push_back(it);
  endtask

  task automatic gen_mix(int n, int w_push, int w_pop, int w_rem, int w_clr);
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(w_push + w_pop + w_rem + w_clr - 1);
      if (roll < w_push)
        queue_op(OP_PUSH, rand_word(), rand_word(), HANDLE_W'($urandom), 1'b0);
      else if (roll < w_push + w_pop)
        queue_op(OP_POP, rand_word(), rand_word(), HANDLE_W'($urandom), 1'b0);
      else if (roll < w_push + w_pop + w_rem)
        queue_op(OP_REMOVE, rand_word(), rand_word(), HANDLE_W'($urandom),
                 $urandom_range(9) < 8);
      else
        queue_op(OP_CLEAR, rand_word(), rand_word(), HANDLE_W'($urandom), 1'b0);
    end
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    if (errors <= PRINT_MAX)
      $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
  endtask

  // driver
  always @(posedge clk) begin : drive_proc
    plq_item_t   nxt;
    plq_result_t res;
    bit          fire;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      fire = in_ch.valid && in_ch.ready;
      if (fire) begin
        res = predict_op(cur_op);
        expected_results.push_back(res);
        op_count[int'(cur_op.op)]++;
        status_count[int'(res.status)]++;
      end
      if (!in_ch.valid || fire) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_ops.pop_front();
          if (nxt.pick_live) nxt.slot_handle = live_handle(nxt.slot_handle);
          cur_op = nxt;
          in_ch.operation   <= nxt.op;
          in_ch.order_id    <= nxt.order_id;
          in_ch.order_qty   <= nxt.order_qty;
          in_ch.slot_handle <= nxt.slot_handle;
          in_ch.valid       <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : mon_proc
    plq_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transfer", 64'(out_ch.status), 64'(0));
        end else begin
          want = expected_results.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch("status", 64'(out_ch.status), 64'(want.status));
          if (out_ch.new_handle !== want.new_handle)
            report_mismatch("new_handle", 64'(out_ch.new_handle), 64'(want.new_handle));
          if (out_ch.popped_id !== want.popped_id)
            report_mismatch("popped_id", 64'(out_ch.popped_id), 64'(want.popped_id));
          if (out_ch.popped_qty !== want.popped_qty)
            report_mismatch("popped_qty", 64'(out_ch.popped_qty), 64'(want.popped_qty));
          if (out_ch.head_id !== want.head_id)
            report_mismatch("head_id", 64'(out_ch.head_id), 64'(want.head_id));
          if (out_ch.is_empty !== want.is_empty)
            report_mismatch("is_empty", 64'(out_ch.is_empty), 64'(want.is_empty));
          if (out_ch.level_total !== want.level_total)
            report_mismatch("level_total", 64'(out_ch.level_total), 64'(want.level_total));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog: cycles with work outstanding but no transfer on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (pending_ops.size() == 0 && !in_ch.valid && expected_results.size() == 0)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_MAX) begin
        $display("watchdog expired: no transfer for %0d cycles", STALL_MAX);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.operation   = OP_PUSH;
    in_ch.order_id    = '0;
    in_ch.order_qty   = '0;
    in_ch.slot_handle = '0;
    out_ch.ready      = 1'b0;
    rst_n             = 1'b0;
    slot_busy         = '0;
    head_slot_q       = '0;
    tail_slot_q       = '0;
    has_orders        = 1'b0;
    level_sum         = '0;
    errors            = 0;
    results_seen      = 0;
    stall_cycles      = 0;
    send_idle_pct     = 21;
    recv_idle_pct     = 57;
    foreach (op_count[i]) op_count[i] = 0;
    foreach (status_count[i]) status_count[i] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty errors, extremes, unlink at head, middle and tail, clear
    queue_op(OP_POP,    32'h0,        32'h0,        6'd0,  1'b0);
    queue_op(OP_REMOVE, 32'h0,        32'h0,        6'd0,  1'b0);
    queue_op(OP_REMOVE, 32'hFFFFFFFF, 32'hFFFFFFFF, 6'd63, 1'b0);
    queue_op(OP_PUSH,   32'h0,        32'h0,        6'd63, 1'b0);
    queue_op(OP_PUSH,   32'hFFFFFFFF, 32'hFFFFFFFF, 6'd0,  1'b0);
    queue_op(OP_PUSH,   32'h55555555, 32'hAAAAAAAA, 6'd21, 1'b0);
    queue_op(OP_PUSH,   32'hAAAAAAAA, 32'hFFFFFFFF, 6'd42, 1'b0);
    queue_op(OP_PUSH,   32'h12345678, 32'hFFFFFFFF, 6'd0,  1'b0);
    queue_op(OP_REMOVE, 32'h0,        32'h0,        6'd2,  1'b0);
    queue_op(OP_REMOVE, 32'h0,        32'h0,        6'd4,  1'b0);
    queue_op(OP_REMOVE, 32'h0,        32'h0,        6'd0,  1'b0);
    queue_op(OP_REMOVE, 32'h0,        32'h0,        6'd0,  1'b0);
    queue_op(OP_POP,    32'h0,        32'h0,        6'd0,  1'b0);
    queue_op(OP_POP,    32'h0,        32'h0,        6'd0,  1'b0);
    queue_op(OP_REMOVE, 32'h0,        32'h0,        6'd3,  1'b0);
    queue_op(OP_POP,    32'h0,        32'h0,        6'd0,  1'b0);
    queue_op(OP_PUSH,   32'hDEADBEEF, 32'h00000001, 6'd0,  1'b0);
    queue_op(OP_REMOVE, 32'h0,        32'h0,        6'd0,  1'b0);
    queue_op(OP_PUSH,   32'h00000001, 32'h80000000, 6'd0,  1'b0);
    queue_op(OP_PUSH,   32'h80000000, 32'h7FFFFFFF, 6'd0,  1'b0);
    queue_op(OP_CLEAR,  32'h0,        32'h0,        6'd0,  1'b0);
    queue_op(OP_CLEAR,  32'hFFFFFFFF, 32'hFFFFFFFF, 6'd63, 1'b0);
    queue_op(OP_POP,    32'h0,        32'h0,        6'd0,  1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 57;
        recv_idle_pct = 21;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // fill toward a full pool, churn, then drain
      queue_op(OP_CLEAR, rand_word(), rand_word(), HANDLE_W'($urandom), 1'b0);
      gen_mix(80, 90, 4, 6, 0);
      gen_mix(60, 40, 25, 30, 5);
      gen_mix(59, 10, 45, 45, 0);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("ran %0d push, %0d pop, %0d remove, %0d clear; %0d results compared",
             op_count[0], op_count[1], op_count[2], op_count[3], results_seen);
    $display("outcomes: %0d ok, %0d pop on empty, %0d pool full, %0d bad handle",
             status_count[0], status_count[1], status_count[2], status_count[3]);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, expected_results.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/plq_pkg.sv
hdl/plq_channels.sv
hdl/plq_slot_map.sv
hdl/plq_node_mem.sv
hdl/price_level_order_queue.sv
hdl/plq_checker.sv
tb/tb_price_level_order_queue.sv
